FILE: rtl/osc_pkg.sv
// ----------------------------------------------------------------------------
// osc_pkg
// Shared constants, payload types and helpers for the box-box contact pipe.
// ----------------------------------------------------------------------------
package osc_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int FRACTION_BITS   = 8;
  localparam int TESTED_AXES     = 2;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int FB    = FRACTION_BITS;
  localparam int NAX   = 2 * TESTED_AXES;
  localparam int NCOL  = 6;
  localparam int BW    = (NAX > 1) ? $clog2(NAX) : 1;
  localparam int PW    = 2 * CW;
  localparam int DOTW  = PW + 2;
  localparam int DW    = CW + 1;
  localparam int DDW   = DW + CW + 2;
  localparam int MW    = DOTW - FB;
  localparam int EPW   = CW + MW;
  localparam int EXTW  = EPW + 3;
  localparam int PENW  = ((EXTW > DDW) ? EXTW : DDW) + 1;
  localparam int SUMW  = DW + CW + 2;
  localparam int PTW   = SUMW + 1;
  localparam int DEPW  = 16;

  typedef logic [47:0] vec_t;

  typedef struct packed {
    vec_t a_axis_x;
    vec_t a_axis_y;
    vec_t a_axis_z;
    vec_t a_centre;
    vec_t a_half_size;
    vec_t b_axis_x;
    vec_t b_axis_y;
    vec_t b_axis_z;
    vec_t b_centre;
    vec_t b_half_size;
  } obb_in_t;

  typedef struct packed {
    logic            hit;
    logic            reference_is_b;
    logic            face_index;
    vec_t            contact_normal;
    vec_t            contact_point;
    logic [DEPW-1:0] depth;
  } obb_out_t;

  // Penetration stage result, one entry per tested axis.
  typedef struct packed {
    logic                      valid;
    obb_in_t                   req;
    logic [NAX-1:0][PENW-1:0]  pen;
    logic [NAX-1:0]            dpos;
    logic [NAX-1:0]            dneg;
  } pen_t;

  // Winning axis and the data of the box that supplies the vertex.
  typedef struct packed {
    logic            valid;
    logic            hit;
    logic            ref_b;
    logic            face;
    vec_t            nrm;
    logic [DEPW-1:0] depth;
    vec_t            oc0;
    vec_t            oc1;
    vec_t            oc2;
    vec_t            octr;
    vec_t            oh;
  } sel_t;

  function automatic logic signed [CW-1:0] comp(vec_t v, int k);
    return v[k*CW +: CW];
  endfunction

  // Columns 0..2 belong to box A, 3..5 to box B.
  function automatic vec_t box_col(obb_in_t r, int j);
    vec_t c;
    unique case (j)
      0: c = r.a_axis_x;
      1: c = r.a_axis_y;
      2: c = r.a_axis_z;
      3: c = r.b_axis_x;
      4: c = r.b_axis_y;
      5: c = r.b_axis_z;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Axes are tested in the order A0, B0, A1, B1, ...
  function automatic int axis_col(int i);
    return (i & 1) * 3 + (i >> 1);
  endfunction

endpackage

FILE: rtl/osc_pen.sv
// ----------------------------------------------------------------------------
// osc_pen
// Four-stage penetration unit: dot products, magnitudes, projected extents
// and the signed penetration on every tested axis.
// ----------------------------------------------------------------------------
module osc_pen import osc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  obb_in_t in_req,
  output pen_t    pout
);

  function automatic logic [CW-1:0] half(obb_in_t r, int j);
    vec_t h;
    h = (j < 3) ? r.a_half_size : r.b_half_size;
    return h[((j < 3) ? j : j - 3)*CW +: CW];
  endfunction

  // Stage 1: products.
  logic                        v1;
  obb_in_t                     r1;
  logic signed [PW-1:0]        pc1 [NAX][NCOL][3];
  logic signed [DW+CW-1:0]     pd1 [NAX][3];
  logic signed [DW-1:0]        dvec [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvec[k] = DW'(comp(in_req.b_centre, k)) - DW'(comp(in_req.a_centre, k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    r1 <= in_req;
    for (int i = 0; i < NAX; i++) begin
      for (int k = 0; k < 3; k++) begin
        pd1[i][k] <= dvec[k] * comp(box_col(in_req, axis_col(i)), k);
        for (int j = 0; j < NCOL; j++) begin
          pc1[i][j][k] <= comp(box_col(in_req, axis_col(i)), k) *
                          comp(box_col(in_req, j), k);
        end
      end
    end
  end

  // Stage 2: dot sums and truncated magnitudes.
  logic                    v2;
  obb_in_t                 r2;
  logic [MW-1:0]           m2 [NAX][NCOL];
  logic [DDW-1:0]          dist2 [NAX];
  logic [NAX-1:0]          dpos2, dneg2;
  logic signed [DOTW-1:0]  dotc [NAX][NCOL];
  logic signed [DDW-1:0]   dotd [NAX];
  logic [DOTW-1:0]         magc [NAX][NCOL];

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      dotd[i] = DDW'(pd1[i][0]) + DDW'(pd1[i][1]) + DDW'(pd1[i][2]);
      for (int j = 0; j < NCOL; j++) begin
        dotc[i][j] = DOTW'(pc1[i][j][0]) + DOTW'(pc1[i][j][1]) + DOTW'(pc1[i][j][2]);
        magc[i][j] = (dotc[i][j] < 0) ? DOTW'(-dotc[i][j]) : DOTW'(dotc[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    r2 <= r1;
    for (int i = 0; i < NAX; i++) begin
      dist2[i] <= (dotd[i] < 0) ? DDW'(-dotd[i]) : DDW'(dotd[i]);
      dpos2[i] <= dotd[i] > 0;
      dneg2[i] <= dotd[i] < 0;
      for (int j = 0; j < NCOL; j++) begin
        m2[i][j] <= MW'(magc[i][j] >> FB);
      end
    end
  end

  // Stage 3: extent terms. They stay far below the 2^62 cap at these widths.
  logic              v3;
  obb_in_t           r3;
  logic [EPW-1:0]    ep3 [NAX][NCOL];
  logic [DDW-1:0]    dist3 [NAX];
  logic [NAX-1:0]    dpos3, dneg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    r3    <= r2;
    dpos3 <= dpos2;
    dneg3 <= dneg2;
    for (int i = 0; i < NAX; i++) begin
      dist3[i] <= dist2[i];
      for (int j = 0; j < NCOL; j++) begin
        ep3[i][j] <= EPW'(half(r2, j)) * EPW'(m2[i][j]);
      end
    end
  end

  // Stage 4: penetration = distance - summed extents.
  logic [EXTW-1:0] ext [NAX];

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      ext[i] = '0;
      for (int j = 0; j < NCOL; j++) begin
        ext[i] = ext[i] + EXTW'(ep3[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else begin
      pout.valid <= v3;
    end
    pout.req  <= r3;
    pout.dpos <= dpos3;
    pout.dneg <= dneg3;
    for (int i = 0; i < NAX; i++) begin
      pout.pen[i] <= PENW'(dist3[i]) - PENW'(ext[i]);
    end
  end

endmodule

FILE: rtl/osc_sel.sv
// ----------------------------------------------------------------------------
// osc_sel
// Separation check, least-deep axis choice, oriented normal and depth.
// ----------------------------------------------------------------------------
module osc_sel import osc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  pen_t pin,
  output sel_t sout
);

  logic                    any_pos;
  logic [BW-1:0]           best;
  logic signed [PENW-1:0]  bp;
  logic                    ref_b;
  logic                    flip;
  int                      cidx;
  vec_t                    col;
  vec_t                    nrm;
  logic [PENW-1:0]         dm;
  logic [DEPW-1:0]         depth;
  logic signed [CW-1:0]    ck;

  always_comb begin
    any_pos = 1'b0;
    best    = '0;
    bp      = $signed(pin.pen[0]);
    for (int i = 0; i < NAX; i++) begin
      if ($signed(pin.pen[i]) > 0) any_pos = 1'b1;
    end
    // Strict compare keeps the earlier axis on ties.
    for (int i = 1; i < NAX; i++) begin
      if ($signed(pin.pen[i]) > bp) begin
        bp   = $signed(pin.pen[i]);
        best = BW'(i);
      end
    end
    ref_b = best[0];
    cidx  = (ref_b ? 3 : 0) + int'(best >> 1);
    col   = box_col(pin.req, cidx);
    // Reference B sees the centre offset reversed.
    flip  = ref_b ? pin.dneg[best] : pin.dpos[best];
    for (int k = 0; k < 3; k++) begin
      ck = comp(col, k);
      if (flip) begin
        if (ck == {1'b1, {(CW-1){1'b0}}}) ck = {1'b0, {(CW-1){1'b1}}};
        else                              ck = -ck;
      end
      nrm[k*CW +: CW] = ck;
    end
    dm    = PENW'(-bp) >> FB;
    depth = (dm > PENW'({DEPW{1'b1}})) ? {DEPW{1'b1}} : dm[DEPW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sout.valid <= 1'b0;
    end else begin
      sout.valid <= pin.valid;
    end
    sout.hit   <= ~any_pos;
    sout.ref_b <= ref_b;
    sout.face  <= best[1];
    sout.nrm   <= nrm;
    sout.depth <= depth;
    sout.oc0   <= ref_b ? pin.req.a_axis_x    : pin.req.b_axis_x;
    sout.oc1   <= ref_b ? pin.req.a_axis_y    : pin.req.b_axis_y;
    sout.oc2   <= ref_b ? pin.req.a_axis_z    : pin.req.b_axis_z;
    sout.octr  <= ref_b ? pin.req.a_centre    : pin.req.b_centre;
    sout.oh    <= ref_b ? pin.req.a_half_size : pin.req.b_half_size;
  end

endmodule

FILE: rtl/osc_cpt.sv
// ----------------------------------------------------------------------------
// osc_cpt
// Deepest vertex of the incident box and its world position, four stages.
// ----------------------------------------------------------------------------
module osc_cpt import osc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  sel_t     sin,
  output logic     done,
  output obb_out_t rsp
);

  function automatic vec_t ocol(sel_t s, int j);
    vec_t c;
    unique case (j)
      0: c = s.oc0;
      1: c = s.oc1;
      2: c = s.oc2;
      default: c = '0;
    endcase
    return c;
  endfunction

  localparam logic signed [PTW-1:0] PMAX = PTW'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [PTW-1:0] PMIN = -PMAX - 1;

  // Stage 6: column-by-normal products.
  sel_t                  s6;
  logic signed [PW-1:0]  pn6 [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6.valid <= 1'b0;
    end else begin
      s6.valid <= sin.valid;
    end
    s6[$bits(sel_t)-2:0] <= sin[$bits(sel_t)-2:0];
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        pn6[j][k] <= comp(ocol(sin, j), k) * comp(sin.nrm, k);
      end
    end
  end

  // Stage 7: vertex signs.
  sel_t          s7;
  logic [2:0]    neg7;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7.valid <= 1'b0;
    end else begin
      s7.valid <= s6.valid;
    end
    s7[$bits(sel_t)-2:0] <= s6[$bits(sel_t)-2:0];
    for (int j = 0; j < 3; j++) begin
      neg7[j] <= (DOTW'(pn6[j][0]) + DOTW'(pn6[j][1]) + DOTW'(pn6[j][2])) < 0;
    end
  end

  // Stage 8: signed half size times column.
  sel_t                     s8;
  logic signed [DW+CW-1:0]  pv8 [3][3];
  logic signed [DW-1:0]     vj [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      vj[j] = $signed({1'b0, s7.oh[j*CW +: CW]});
      if (neg7[j]) vj[j] = -vj[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8.valid <= 1'b0;
    end else begin
      s8.valid <= s7.valid;
    end
    s8[$bits(sel_t)-2:0] <= s7[$bits(sel_t)-2:0];
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        pv8[j][k] <= vj[j] * comp(ocol(s7, j), k);
      end
    end
  end

  // Stage 9: floor shift, add the centre, saturate, gate on a miss.
  logic signed [SUMW-1:0] psum [3];
  logic signed [PTW-1:0]  pt [3];
  vec_t                   point;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = SUMW'(pv8[0][k]) + SUMW'(pv8[1][k]) + SUMW'(pv8[2][k]);
      pt[k]   = PTW'(psum[k] >>> FB) + PTW'(comp(s8.octr, k));
      if (pt[k] > PMAX)      point[k*CW +: CW] = PMAX[CW-1:0];
      else if (pt[k] < PMIN) point[k*CW +: CW] = PMIN[CW-1:0];
      else                   point[k*CW +: CW] = pt[k][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s8.valid;
    end
    if (s8.hit) begin
      rsp.hit            <= 1'b1;
      rsp.reference_is_b <= s8.ref_b;
      rsp.face_index     <= s8.face;
      rsp.contact_normal <= s8.nrm;
      rsp.contact_point  <= point;
      rsp.depth          <= s8.depth;
    end else begin
      rsp <= '0;
    end
  end

endmodule

FILE: rtl/obb_sat_contact.sv
// ----------------------------------------------------------------------------
// obb_sat_contact
// Separating-axis contact test for a pair of oriented boxes.
// ----------------------------------------------------------------------------
// A box pair is taken on every cycle that start is high; busy never rises.
// Each item gives one result, shown for one cycle with done high, after it
// passes the four-stage penetration unit, the axis select stage and the
// four-stage contact point unit. The receiver cannot stall, so results
// must be captured the cycle they appear.
module obb_sat_contact import osc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  obb_in_t  req,
  output logic     done,
  output obb_out_t rsp
);

  pen_t pen;
  sel_t sel;

  assign busy = 1'b0;

  osc_pen u_pen (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .in_req   (req),
    .pout     (pen)
  );

  osc_sel u_sel (
    .clk  (clk),
    .rst  (rst),
    .pin  (pen),
    .sout (sel)
  );

  osc_cpt u_cpt (
    .clk  (clk),
    .rst  (rst),
    .sin  (sel),
    .done (done),
    .rsp  (rsp)
  );

endmodule

FILE: test/obb_contact_checker.sv
// ----------------------------------------------------------------------------
// obb_contact_checker
// Watches the box pair and contact channels, predicts each contact from the
// accepted box pair and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
module obb_contact_checker import osc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  obb_in_t  req,
  input  logic     done,
  input  obb_out_t rsp,
  output int       fail_count,
  output int       pending,
  output logic     accepted
);

  localparam longint EXT_CAP = 64'sd1 <<< 62;
  localparam longint COMP_HI = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COMP_LO = -COMP_HI - 1;

  typedef longint vec3_t [3];

  obb_out_t contact_fifo[$];
  int       mismatch_count;

  assign pending  = contact_fifo.size();
  assign accepted = (start && !busy) || done;
  assign fail_count = mismatch_count;

  function automatic void unpack_vec(vec_t w, output vec3_t v);
    for (int k = 0; k < 3; k++) v[k] = longint'($signed(w[k*CW +: CW]));
  endfunction

  function automatic longint dot_prod(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic longint abs_val(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint clamp_comp(longint x);
    return x > COMP_HI ? COMP_HI : (x < COMP_LO ? COMP_LO : x);
  endfunction

  // Projected extent of a box; products and sums saturate at 2^62.
  function automatic longint box_extent(vec3_t c0, vec3_t c1, vec3_t c2,
                                        vec3_t h, vec3_t axis);
    longint s, m, p;
    vec3_t cols [3];
    s = 0;
    cols[0] = c0; cols[1] = c1; cols[2] = c2;
    for (int k = 0; k < 3; k++) begin
      m = abs_val(dot_prod(axis, cols[k])) >>> FB;
      if (h[k] != 0 && m > EXT_CAP / h[k]) p = EXT_CAP;
      else p = h[k] * m;
      if (p > EXT_CAP) p = EXT_CAP;
      s = s + p;
      if (s > EXT_CAP) s = EXT_CAP;
    end
    return s;
  endfunction

  function automatic obb_out_t predict_contact(obb_in_t r);
    obb_out_t o;
    vec3_t    cols [6];
    vec3_t    ca, cb, ha, hb, d, axis, nrm, rc, oc, oh, ocol [3];
    longint   ext, pen, best_pen, sum, v, dep, fl;
    int       best, face;
    bit       ref_b;
    o = '0;
    for (int j = 0; j < 6; j++) unpack_vec(box_col(r, j), cols[j]);
    unpack_vec(r.a_centre, ca);
    unpack_vec(r.b_centre, cb);
    for (int k = 0; k < 3; k++) begin
      ha[k] = longint'(r.a_half_size[k*CW +: CW]);
      hb[k] = longint'(r.b_half_size[k*CW +: CW]);
      d[k]  = cb[k] - ca[k];
    end
    best = -1;
    best_pen = 0;
    for (int i = 0; i < NAX; i++) begin
      axis = cols[axis_col(i)];
      ext = box_extent(cols[0], cols[1], cols[2], ha, axis)
          + box_extent(cols[3], cols[4], cols[5], hb, axis);
      if (ext > EXT_CAP) ext = EXT_CAP;
      pen = abs_val(dot_prod(d, axis)) - ext;
      if (pen > 0) return '0;
      if (best < 0 || pen > best_pen) begin
        best_pen = pen;
        best = i;
      end
    end
    face  = best >> 1;
    ref_b = best & 1;
    for (int k = 0; k < 3; k++) begin
      rc[k] = ref_b ? cb[k] : ca[k];
      oc[k] = ref_b ? ca[k] : cb[k];
      oh[k] = ref_b ? ha[k] : hb[k];
    end
    for (int j = 0; j < 3; j++) ocol[j] = cols[(ref_b ? 0 : 3) + j];
    nrm = cols[(ref_b ? 3 : 0) + face];
    for (int k = 0; k < 3; k++) d[k] = oc[k] - rc[k];
    if (dot_prod(nrm, d) > 0)
      for (int k = 0; k < 3; k++) nrm[k] = clamp_comp(-nrm[k]);
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        v = oh[j];
        if (dot_prod(ocol[j], nrm) < 0) v = -v;
        sum += v * ocol[j][k];
      end
      fl = sum >>> FB;  // arithmetic shift rounds toward minus infinity
      o.contact_point[k*CW +: CW] = clamp_comp(oc[k] + fl);
      o.contact_normal[k*CW +: CW] = nrm[k];
    end
    dep = abs_val(best_pen) >>> FB;
    if (dep > 65535) dep = 65535;
    o.hit            = 1'b1;
    o.reference_is_b = ref_b;
    o.face_index     = face[0];
    o.depth          = dep[DEPW-1:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    obb_out_t exp_c;
    if (rst) begin
      mismatch_count <= 0;
    end else begin
      if (start && !busy) contact_fifo.push_back(predict_contact(req));
      if (done) begin
        if (contact_fifo.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected contact %h", rsp);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_c = contact_fifo.pop_front();
          if (exp_c.hit !== rsp.hit || exp_c.reference_is_b !== rsp.reference_is_b ||
              exp_c.face_index !== rsp.face_index ||
              exp_c.contact_normal !== rsp.contact_normal ||
              exp_c.contact_point !== rsp.contact_point || exp_c.depth !== rsp.depth) begin
            if (mismatch_count < 10)
              $display("contact mismatch: expected %h, got %h", exp_c, rsp);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives directed and random box pairs into the contact pipe with random
// gaps and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import osc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  obb_in_t  req;
  logic     done;
  obb_out_t rsp;
  int       fail_count;
  int       pending;
  logic     accepted;
  int       idle_cycles;
  bit       timed_out;

  obb_sat_contact dut (.clk, .rst, .start, .busy, .req, .done, .rsp);

  obb_contact_checker checker_i (.clk, .rst, .start, .busy, .req, .done, .rsp,
                                 .fail_count, .pending, .accepted);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      timed_out   <= 1'b0;
    end else begin
      if (accepted) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end
  end

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 512) - 256);
      2: return 16'($urandom_range(0, 64) - 32);
      default: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  function automatic vec_t rand_vec(int mode);
    return {rand_comp(mode), rand_comp(mode), rand_comp(mode)};
  endfunction

  // Mostly small, overlapping boxes so that hits are common.
  function automatic obb_in_t rand_pair();
    obb_in_t r;
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) begin
      r.a_axis_x = rand_vec(1); r.a_axis_y = rand_vec(1); r.a_axis_z = rand_vec(1);
      r.b_axis_x = rand_vec(1); r.b_axis_y = rand_vec(1); r.b_axis_z = rand_vec(1);
      r.a_centre = rand_vec(2); r.b_centre = rand_vec(2);
      r.a_half_size = {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                       16'($urandom_range(0, 1024))};
      r.b_half_size = {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                       16'($urandom_range(0, 1024))};
    end else if (m < 9) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      r.a_axis_x = rand_vec(3); r.a_axis_y = rand_vec(3); r.a_axis_z = rand_vec(3);
      r.b_axis_x = rand_vec(3); r.b_axis_y = rand_vec(3); r.b_axis_z = rand_vec(3);
      r.a_centre = rand_vec(3); r.b_centre = rand_vec(3);
      r.a_half_size = rand_vec(0); r.b_half_size = rand_vec(0);
    end
    return r;
  endfunction

  function automatic obb_in_t unit_pair(vec_t bctr, vec_t ah, vec_t bh);
    obb_in_t r;
    r.a_axis_x = {16'h0, 16'h0, 16'h0100};
    r.a_axis_y = {16'h0, 16'h0100, 16'h0};
    r.a_axis_z = {16'h0100, 16'h0, 16'h0};
    r.b_axis_x = r.a_axis_x; r.b_axis_y = r.a_axis_y; r.b_axis_z = r.a_axis_z;
    r.a_centre = '0;
    r.b_centre = bctr;
    r.a_half_size = ah;
    r.b_half_size = bh;
    return r;
  endfunction

  task automatic send_pair(obb_in_t r);
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    obb_in_t r;
    vec_t h1;
    start <= 1'b0;
    req   <= '0;
    rst   <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    h1 = {16'h0100, 16'h0100, 16'h0100};
    // Directed: separated, touching, overlapping along each tested axis, all zero,
    // saturating extremes and degenerate columns.
    send_pair(unit_pair({16'h0, 16'h0, 16'h0400}, h1, h1));
    send_pair(unit_pair({16'h0, 16'h0, 16'h0200}, h1, h1));
    send_pair(unit_pair({16'h0, 16'h0, 16'h0180}, h1, h1));
    send_pair(unit_pair({16'h0, 16'h0180, 16'h0}, h1, h1));
    send_pair(unit_pair({16'h0, 16'hfe80, 16'h0010}, h1, h1));
    send_pair(unit_pair({16'h0, 16'h0010, 16'hfe70}, h1, h1));
    send_pair('0);
    send_pair('1);
    r = '0;
    r.a_half_size = '1; r.b_half_size = '1;
    send_pair(r);
    r = {10{48'h8000_8000_8000}};
    send_pair(r);
    r = {10{48'h7fff_7fff_7fff}};
    send_pair(r);
    r = {10{48'h8000_7fff_8000}};
    r.a_half_size = '1; r.b_half_size = '1;
    send_pair(r);
    r = unit_pair({16'h7fff, 16'h7fff, 16'h7fff}, '1, '1);
    r.b_axis_x = {16'h0, 16'h0, 16'h8000};
    send_pair(r);
    r = unit_pair({16'h8000, 16'h8000, 16'h8000}, '1, '1);
    r.a_axis_x = {16'h0, 16'h0, 16'h8000};
    send_pair(r);
    r = unit_pair('0, h1, h1);
    r.a_axis_x = '0;
    send_pair(r);
    r = unit_pair({16'h0, 16'h0, 16'h0080}, h1, h1);
    r.b_axis_y = '0;
    send_pair(r);
    for (int i = 0; i < 1250; i++) begin
      send_pair(rand_pair());
      if (i == 600) begin
        start <= 1'b0;
        while (pending != 0 && !timed_out) @(posedge clk);
      end else if (i > 200) begin
        idle_gap();
      end
    end
    start <= 1'b0;
    while (pending != 0 && !timed_out) @(posedge clk);
    repeat (20) @(posedge clk);
    if (timed_out) begin
      $display("CHECK FAILED");
    end else if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
